// ----- src/bdpc_pkg.sv -----
// shared types and constants for the button debounce and press classifier
// no dependencies
`default_nettype none

package bdpc_pkg;

    localparam int unsigned TIME_W = 32;
    localparam int unsigned CFG_W  = 16;
    localparam int unsigned APB_AW = 4;
    localparam int unsigned APB_DW = 32;

    // register indexes (byte address / 4)
    localparam logic [1:0] REG_DEBOUNCE  = 2'd0;
    localparam logic [1:0] REG_LONG_PRESS = 2'd1;
    localparam logic [1:0] REG_MIN_GAP   = 2'd2;

    localparam logic [CFG_W-1:0] DEBOUNCE_RST   = 16'd50;
    localparam logic [CFG_W-1:0] LONG_PRESS_RST = 16'd1000;
    localparam logic [CFG_W-1:0] MIN_GAP_RST    = 16'd300;

    typedef struct packed {
        logic [CFG_W-1:0] debounce_ms;
        logic [CFG_W-1:0] long_press_ms;
        logic [CFG_W-1:0] min_event_gap_ms;
    } cfg_t;

    typedef struct packed {
        logic valid;
        logic long_press;
    } event_t;

endpackage

`default_nettype wire

// ----- src/bdpc_regs.sv -----
// apb configuration registers for the press classifier
// depends on bdpc_pkg
`default_nettype none

module bdpc_regs (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [bdpc_pkg::APB_AW-1:0]   paddr,
    input  wire logic [bdpc_pkg::APB_DW-1:0]   pwdata,
    output logic      [bdpc_pkg::APB_DW-1:0]   prdata,
    output logic                               pready,
    output bdpc_pkg::cfg_t                     cfg
);
    import bdpc_pkg::*;

    logic [1:0]       reg_idx;
    logic             wr_en;
    cfg_t             cfg_reg;
    cfg_t             cfg_next;
    logic [CFG_W-1:0] rd_val;

    assign reg_idx = paddr[APB_AW-1:2];
    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign cfg     = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            case (reg_idx)
                REG_DEBOUNCE:   cfg_next.debounce_ms      = pwdata[CFG_W-1:0];
                REG_LONG_PRESS: cfg_next.long_press_ms    = pwdata[CFG_W-1:0];
                REG_MIN_GAP:    cfg_next.min_event_gap_ms = pwdata[CFG_W-1:0];
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_DEBOUNCE:   rd_val = cfg_reg.debounce_ms;
            REG_LONG_PRESS: rd_val = cfg_reg.long_press_ms;
            REG_MIN_GAP:    rd_val = cfg_reg.min_event_gap_ms;
            default:        rd_val = '0;
        endcase
    end

    assign prdata = {{(APB_DW-CFG_W){1'b0}}, rd_val};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.debounce_ms      <= DEBOUNCE_RST;
            cfg_reg.long_press_ms    <= LONG_PRESS_RST;
            cfg_reg.min_event_gap_ms <= MIN_GAP_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

`default_nettype wire

// ----- src/bdpc_core.sv -----
// debounce state and short/long press decision for one sample per cycle while step is high
// depends on bdpc_pkg
`default_nettype none

module bdpc_core (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          step,
    input  wire logic                          level,
    input  wire logic [bdpc_pkg::TIME_W-1:0]   time_ms,
    input  wire bdpc_pkg::cfg_t                cfg,
    output bdpc_pkg::event_t                   evt
);
    import bdpc_pkg::*;

    logic              last_level_reg;
    logic              stable_level_reg;
    logic              long_reported_reg;
    logic [TIME_W-1:0] change_stamp_reg;
    logic [TIME_W-1:0] press_stamp_reg;
    logic [TIME_W-1:0] event_stamp_reg;

    logic              last_level_next;
    logic              stable_level_next;
    logic              long_reported_next;
    logic [TIME_W-1:0] change_stamp_next;
    logic [TIME_W-1:0] press_stamp_next;
    logic [TIME_W-1:0] event_stamp_next;

    logic              changed;
    logic [TIME_W-1:0] chg_diff;
    logic [TIME_W-1:0] press_diff;
    logic [TIME_W-1:0] hold_diff;
    logic [TIME_W-1:0] gap_diff;
    logic [TIME_W-1:0] debounce_ext;
    logic [TIME_W-1:0] long_ext;
    logic [TIME_W-1:0] gap_ext;
    logic              settled;
    logic              trans;
    logic              press;
    logic              release_ev;
    logic              gap_ok;
    logic              short_ev;
    logic              stable_eff;
    logic              long_rep_eff;
    logic              long_hit;
    logic              long_ev;

    assign debounce_ext = {{(TIME_W-CFG_W){1'b0}}, cfg.debounce_ms};
    assign long_ext     = {{(TIME_W-CFG_W){1'b0}}, cfg.long_press_ms};
    assign gap_ext      = {{(TIME_W-CFG_W){1'b0}}, cfg.min_event_gap_ms};

    always_comb begin
        changed      = level != last_level_reg;
        chg_diff     = changed ? '0 : time_ms - change_stamp_reg;
        settled      = chg_diff >= debounce_ext;
        trans        = settled && (level != stable_level_reg);
        press        = trans && level;
        release_ev   = trans && !level;
        press_diff   = time_ms - press_stamp_reg;
        gap_diff     = time_ms - event_stamp_reg;
        gap_ok       = gap_diff >= gap_ext;
        short_ev     = release_ev && !long_reported_reg && (press_diff < long_ext) && gap_ok;
        stable_eff   = trans ? level : stable_level_reg;
        long_rep_eff = press ? 1'b0 : long_reported_reg;
        hold_diff    = press ? '0 : press_diff;
        long_hit     = settled && stable_eff && !long_rep_eff && (hold_diff >= long_ext);
        long_ev      = long_hit && gap_ok;

        evt.valid      = short_ev || long_ev;
        evt.long_press = long_ev;

        last_level_next    = last_level_reg;
        stable_level_next  = stable_level_reg;
        long_reported_next = long_reported_reg;
        change_stamp_next  = change_stamp_reg;
        press_stamp_next   = press_stamp_reg;
        event_stamp_next   = event_stamp_reg;
        if (step) begin
            last_level_next = level;
            if (changed) begin
                change_stamp_next = time_ms;
            end
            if (settled) begin
                stable_level_next  = stable_eff;
                long_reported_next = long_rep_eff || long_hit;
            end
            if (press) begin
                press_stamp_next = time_ms;
            end
            if (short_ev || long_ev) begin
                event_stamp_next = time_ms;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_level_reg    <= 1'b0;
            stable_level_reg  <= 1'b0;
            long_reported_reg <= 1'b0;
            change_stamp_reg  <= '0;
            press_stamp_reg   <= '0;
            event_stamp_reg   <= '0;
        end else begin
            last_level_reg    <= last_level_next;
            stable_level_reg  <= stable_level_next;
            long_reported_reg <= long_reported_next;
            change_stamp_reg  <= change_stamp_next;
            press_stamp_reg   <= press_stamp_next;
            event_stamp_reg   <= event_stamp_next;
        end
    end

endmodule

`default_nettype wire

// ----- src/button_debounce_press_classifier.sv -----
// top level: input register, classifier core, result register, apb registers
// depends on bdpc_pkg, bdpc_regs, bdpc_core
// Each request carries a button level and a millisecond time stamp. A sample
// is held in an input register, classified combinationally against the debounce
// state, and a short or long press event, if any, lands in a result register.
// One sample is taken every clock cycle when the result side keeps up; the
// rate is set by the state update loop of the core, which registers the new
// state of each sample as it is classified. A sample that makes an event
// moves from the input register into the result register once the result
// side has room. Samples that make no event give no result. Reset takes the
// released state with all time stamps at zero; registers at 0x0, 0x4, 0x8 hold
// debounce_ms, long_press_ms and min_event_gap_ms (16 bits each).
`default_nettype none

module button_debounce_press_classifier (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [39:0]                   s_tdata,  // level, time_ms, zero pad
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic      [7:0]                    m_tdata,  // long_press, zero pad
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [bdpc_pkg::APB_AW-1:0]   paddr,
    input  wire logic [bdpc_pkg::APB_DW-1:0]   pwdata,
    output logic      [bdpc_pkg::APB_DW-1:0]   prdata,
    output logic                               pready
);
    import bdpc_pkg::*;

    cfg_t              cfg;
    event_t            evt;

    logic              in_vld_reg;
    logic              in_level_reg;
    logic [TIME_W-1:0] in_time_reg;
    logic              out_vld_reg;
    logic              out_long_reg;
    logic              advance;
    logic              step;

    assign advance  = !out_vld_reg || m_tready;
    assign step     = in_vld_reg && advance;
    assign s_tready = !in_vld_reg || advance;
    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {7'd0, out_long_reg};

    bdpc_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    bdpc_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (step),
        .level   (in_level_reg),
        .time_ms (in_time_reg),
        .cfg     (cfg),
        .evt     (evt)
    );

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (s_tready) begin
            in_vld_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_level_reg <= s_tdata[0];
            in_time_reg  <= s_tdata[TIME_W:1];
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (advance) begin
            out_vld_reg <= step && evt.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_long_reg <= evt.long_press;
        end
    end

    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled while result register empty");

    a_result_from_item: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(in_vld_reg))
        else $error("result without a sample in the input register");

    a_long_only_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        (step && evt.long_press) |-> evt.valid)
        else $error("long press flagged without an event");

endmodule

`default_nettype wire

// ----- bench/tb_button_debounce_press_classifier.sv -----
// testbench for button_debounce_press_classifier: drives timed button samples
// and apb register writes, checks short/long press events against a local model
// depends on bdpc_pkg and button_debounce_press_classifier
module tb_button_debounce_press_classifier;
    import bdpc_pkg::*;

    localparam int         WATCHDOG_LIMIT = 2000;
    localparam int         SETTLE_CYCLES  = 4;
    localparam logic [1:0] REG_UNUSED     = 2'd3;
    localparam logic       PRESS_SHORT    = 1'b0;
    localparam logic       PRESS_LONG     = 1'b1;

    logic              aclk;
    logic              aresetn;
    logic              s_tvalid;
    logic              s_tready;
    logic [39:0]       s_tdata;   // level, time_ms, zero pad
    logic              m_tvalid;
    logic              m_tready;
    logic [7:0]        m_tdata;   // long_press, zero pad
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [APB_AW-1:0] paddr;
    logic [APB_DW-1:0] pwdata;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    button_debounce_press_classifier dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // press model state
    cfg_t        cfg_model;
    logic        seen_lvl;
    logic        steady_lvl;
    logic [31:0] edge_ts;
    logic [31:0] press_ts;
    logic [31:0] event_ts;
    logic        long_seen;
    logic        press_events_q[$];

    logic [31:0] clock_ms;
    int          burst_left;
    int          sends_issued;
    int          hold_off_cycles;
    int          samples_seen;
    int          short_events;
    int          long_events;
    int          settings_used;
    int          fail_count;
    int          stall_cycles;

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    task automatic classify_sample(input logic lvl, input logic [31:0] now);
        logic [31:0] since_edge;
        logic [31:0] held;
        logic [31:0] since_event;
        if (lvl != seen_lvl) begin
            edge_ts  = now;
            seen_lvl = lvl;
        end
        since_edge = now - edge_ts;
        if (since_edge >= {16'd0, cfg_model.debounce_ms}) begin
            held        = now - press_ts;
            since_event = now - event_ts;
            if (lvl != steady_lvl) begin
                steady_lvl = lvl;
                if (lvl) begin
                    press_ts  = now;
                    long_seen = 1'b0;
                end else if (!long_seen && held < {16'd0, cfg_model.long_press_ms}
                             && since_event >= {16'd0, cfg_model.min_event_gap_ms}) begin
                    event_ts = now;
                    press_events_q.push_back(PRESS_SHORT);
                end
            end
            held        = now - press_ts;
            since_event = now - event_ts;
            if (steady_lvl && !long_seen && held >= {16'd0, cfg_model.long_press_ms}) begin
                long_seen = 1'b1;
                if (since_event >= {16'd0, cfg_model.min_event_gap_ms}) begin
                    event_ts = now;
                    press_events_q.push_back(PRESS_LONG);
                end
            end
        end
    endtask

    // accepted requests feed the model
    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready) begin
            classify_sample(s_tdata[0], s_tdata[32:1]);
            samples_seen++;
        end
    end

    always @(posedge aclk) begin : check_events
        logic exp_kind;
        if (aresetn && m_tvalid && m_tready) begin
            if (press_events_q.size() == 0) begin
                $error("unexpected press event, long_press actual %0d", m_tdata[0]);
                fail_count++;
            end else begin
                exp_kind = press_events_q.pop_front();
                if (m_tdata[0] !== exp_kind) begin
                    $error("long_press mismatch: expected %0d, actual %0d",
                           exp_kind, m_tdata[0]);
                    fail_count++;
                end
                if (m_tdata[7:1] !== 7'd0) begin
                    $error("m_tdata pad mismatch: expected 0, actual %0h", m_tdata[7:1]);
                    fail_count++;
                end
                if (exp_kind == PRESS_LONG) long_events++;
                else short_events++;
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("no progress for %0d cycles, %0d press events outstanding",
                     stall_cycles, press_events_q.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // result side stalls on its own pattern, or holds off on request
    initial begin : result_ready
        int run;
        m_tready <= 1'b0;
        forever begin
            if (hold_off_cycles > 0) begin
                m_tready <= 1'b0;
                repeat (hold_off_cycles) @(posedge aclk);
                hold_off_cycles = 0;
            end else begin
                m_tready <= 1'b1;
                run = $urandom_range(1, 25);
                repeat (run) @(posedge aclk);
                if ($urandom_range(0, 2) != 0) begin
                    m_tready <= 1'b0;
                    run = $urandom_range(1, 5);
                    repeat (run) @(posedge aclk);
                end
            end
        end
    end

    task automatic send_sample(input logic lvl, input logic [31:0] ts);
        int gap;
        if (burst_left == 0) begin
            s_tvalid <= 1'b0;
            gap = $urandom_range(1, 10);
            repeat (gap) @(posedge aclk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 12);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= {7'd0, ts, lvl};
        sends_issued++;
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic sender_idle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic wait_for_results();
        sender_idle();
        while (press_events_q.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_register(input logic [1:0] idx, input logic [15:0] value);
        logic [15:0] junk;
        junk = 16'($urandom());
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {junk, value};
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        case (idx)
            REG_DEBOUNCE:   cfg_model.debounce_ms      = value;
            REG_LONG_PRESS: cfg_model.long_press_ms    = value;
            REG_MIN_GAP:    cfg_model.min_event_gap_ms = value;
            default: ;
        endcase
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic apply_setting(input logic [15:0] db, input logic [15:0] lp,
                                 input logic [15:0] gp);
        wait_for_results();
        write_register(REG_DEBOUNCE, db);
        write_register(REG_LONG_PRESS, lp);
        write_register(REG_MIN_GAP, gp);
        settings_used++;
    endtask

    function automatic logic [31:0] near_value(input logic [31:0] v);
        case ($urandom_range(0, 4))
            0: return (v == 0) ? 32'd0 : v - 1;
            1: return v;
            2: return v + 1;
            default: return $urandom_range(0, 2 * v + 2);
        endcase
    endfunction

    task automatic bounce_to(input logic lvl, input logic [31:0] db);
        int n;
        n = $urandom_range(0, 3);
        for (int i = 0; i < n; i++) begin
            send_sample((i % 2 == 1) ? ~lvl : lvl, clock_ms);
            clock_ms += $urandom_range(0, db / 2 + 1);
        end
        send_sample(lvl, clock_ms);
    endtask

    // one press and release with bounce, hold samples and a pause before it
    task automatic button_cycle();
        logic [31:0] db;
        logic [31:0] lp;
        logic [31:0] hold;
        logic [31:0] step;
        logic [31:0] press_at;
        int          n;
        db = cfg_model.debounce_ms;
        lp = cfg_model.long_press_ms;
        clock_ms += near_value(cfg_model.min_event_gap_ms);
        bounce_to(1'b1, db);
        clock_ms += near_value(db);
        send_sample(1'b1, clock_ms);
        press_at = clock_ms;
        case ($urandom_range(0, 2))
            0: hold = near_value(lp);
            1: hold = $urandom_range(0, lp);
            default: hold = lp + $urandom_range(0, lp + 10);
        endcase
        n    = $urandom_range(0, 3);
        step = hold / (n + 1);
        for (int i = 0; i < n; i++) begin
            clock_ms += step;
            send_sample(1'b1, clock_ms);
        end
        clock_ms = press_at + hold;
        send_sample(1'b1, clock_ms);
        clock_ms += $urandom_range(0, 3);
        bounce_to(1'b0, db);
        clock_ms += near_value(db);
        send_sample(1'b0, clock_ms);
    endtask

    task automatic send_noise();
        logic [31:0] dt;
        case ($urandom_range(0, 3))
            0: dt = $urandom();
            1: dt = $urandom_range(0, 3);
            2: dt = -$urandom_range(1, 100);
            default: dt = $urandom_range(0, 2 * cfg_model.debounce_ms + 2);
        endcase
        clock_ms += dt;
        send_sample(1'($urandom_range(0, 1)), clock_ms);
    endtask

    task automatic run_presses(input int count);
        int start;
        int n;
        start = sends_issued;
        while (sends_issued - start < count) begin
            if ($urandom_range(0, 99) < 80) begin
                button_cycle();
            end else begin
                n = $urandom_range(1, 4);
                repeat (n) send_noise();
            end
            if ($urandom_range(0, 99) < 3) wait_for_results();
        end
    endtask

    // default registers: bounce, short, long, missed long, wrap and backward time
    task automatic test_directed_presses();
        send_sample(1'b0, 32'h0000_0000);
        send_sample(1'b1, 32'd10);
        send_sample(1'b0, 32'd30);
        send_sample(1'b1, 32'd40);
        send_sample(1'b1, 32'd89);
        send_sample(1'b1, 32'd90);
        send_sample(1'b0, 32'd300);
        send_sample(1'b0, 32'd350);
        send_sample(1'b1, 32'd400);
        send_sample(1'b1, 32'd450);
        send_sample(1'b1, 32'd1449);
        send_sample(1'b1, 32'd1450);
        send_sample(1'b0, 32'd2000);
        send_sample(1'b0, 32'd2050);
        send_sample(1'b1, 32'd3000);
        send_sample(1'b1, 32'd3050);
        send_sample(1'b0, 32'd5000);
        send_sample(1'b0, 32'd5050);
        send_sample(1'b1, 32'hFFFF_FFE0);
        send_sample(1'b1, 32'hFFFF_FFFF);
        send_sample(1'b1, 32'h0000_0012);
        send_sample(1'b0, 32'h0000_0100);
        send_sample(1'b0, 32'h0000_0132);
        send_sample(1'b1, 32'h0000_0010);
        send_sample(1'b1, 32'h0000_0005);
    endtask

    // zero debounce and long press with the widest gap; spare address is ignored
    task automatic test_register_extremes();
        apply_setting(16'd0, 16'd0, 16'hFFFF);
        write_register(REG_UNUSED, 16'h0001);
        send_sample(1'b1, 32'h0002_0000);
        send_sample(1'b0, 32'h0002_0001);
        send_sample(1'b1, 32'h0002_0002);
        send_sample(1'b0, 32'h0002_0003);
        send_sample(1'b1, 32'h0003_0000);
        clock_ms = 32'h0003_0000;
    endtask

    task automatic test_random_settings();
        apply_setting(DEBOUNCE_RST, LONG_PRESS_RST, MIN_GAP_RST);
        run_presses(100);
        apply_setting(16'd0, 16'd0, 16'd0);
        run_presses(80);
        apply_setting(16'hFFFF, 16'hFFFF, 16'hFFFF);
        run_presses(80);
        apply_setting(16'd0, 16'hFFFF, 16'd0);
        run_presses(60);
        apply_setting(16'hFFFF, 16'd0, 16'hFFFF);
        run_presses(60);
        repeat (3) begin
            apply_setting(16'($urandom_range(0, 100)), 16'($urandom_range(0, 2000)),
                          16'($urandom_range(0, 800)));
            run_presses(70);
        end
    endtask

    // short press on every release while the result side holds off
    task automatic test_result_backpressure();
        apply_setting(16'd0, 16'hFFFF, 16'd0);
        hold_off_cycles = 300;
        while (m_tready) @(posedge aclk);
        burst_left = 1000;
        for (int i = 0; i < 60; i++) begin
            clock_ms += 1;
            send_sample(i[0], clock_ms);
        end
        burst_left = 0;
        wait_for_results();
    endtask

    initial begin
        aresetn         <= 1'b0;
        s_tvalid        <= 1'b0;
        s_tdata         <= '0;
        psel            <= 1'b0;
        penable         <= 1'b0;
        pwrite          <= 1'b0;
        paddr           <= '0;
        pwdata          <= '0;
        cfg_model.debounce_ms      = DEBOUNCE_RST;
        cfg_model.long_press_ms    = LONG_PRESS_RST;
        cfg_model.min_event_gap_ms = MIN_GAP_RST;
        seen_lvl        = 1'b0;
        steady_lvl      = 1'b0;
        edge_ts         = '0;
        press_ts        = '0;
        event_ts        = '0;
        long_seen       = 1'b0;
        clock_ms        = '0;
        burst_left      = 0;
        sends_issued    = 0;
        hold_off_cycles = 0;
        samples_seen    = 0;
        short_events    = 0;
        long_events     = 0;
        settings_used   = 1;
        fail_count      = 0;
        stall_cycles    = 0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed_presses();
        test_register_extremes();
        test_random_settings();
        test_result_backpressure();

        wait_for_results();
        $display("%0d button samples over %0d register settings, %0d short and %0d long presses",
                 samples_seen, settings_used, short_events, long_events);
        if (fail_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("%0d mismatches", fail_count);
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
src/bdpc_pkg.sv
src/bdpc_regs.sv
src/bdpc_core.sv
src/button_debounce_press_classifier.sv
bench/tb_button_debounce_press_classifier.sv
